// ===== src/beep_burst_generator_top_assert.svh =====
// -----------------------------------------------------------------------------
// beep burst generator assertion macros
// concurrent checks clocked on clk, disabled while arst_n is low
// -----------------------------------------------------------------------------
`ifndef BEEP_BURST_GENERATOR_TOP_ASSERT_SVH
`define BEEP_BURST_GENERATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define BBG_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error("beep burst generator check failed");
`define BBG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("beep burst generator check failed");
`else
`define BBG_ASSERT(lbl, prop)
`define BBG_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/bbg_pkg.sv =====
// -----------------------------------------------------------------------------
// bbg_pkg
// types and constants shared by the beep burst generator modules
// -----------------------------------------------------------------------------
`default_nettype none

package bbg_pkg;

	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_BEEPS_PER_BURST = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ON_TIME = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_TIME = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_WAIT = 2'd3;

	localparam logic [7:0] RST_BEEPS_PER_BURST = 8'd2;
	localparam logic [15:0] RST_ON_TIME = 16'd90;
	localparam logic [15:0] RST_GAP_TIME = 16'd50;
	localparam logic [15:0] RST_REPEAT_WAIT = 16'd0;

	typedef struct packed {
		logic [31:0] now_ms;
		logic beep_enable;
		logic start_pulse;
		logic cancel_pulse;
	} in_item_t;

	typedef struct packed {
		logic buzzer_on;
		logic [7:0] beeps_left;
	} out_item_t;

	typedef struct packed {
		logic [7:0] beeps_per_burst;
		logic [15:0] on_time_ms;
		logic [15:0] gap_time_ms;
		logic [15:0] repeat_wait_ms;
	} cfg_t;

	typedef struct packed {
		logic start_pending;
		logic pin_active;
		logic [31:0] phase_stamp;
		logic [7:0] remaining;
	} state_t;

endpackage

`default_nettype wire

// ===== src/bbg_step.sv =====
// -----------------------------------------------------------------------------
// bbg_step
// next-state and result logic for one input item of the beep burst generator
// -----------------------------------------------------------------------------
`default_nettype none

module bbg_step (
	input  bbg_pkg::state_t   cur,
	input  bbg_pkg::cfg_t     cfg,
	input  bbg_pkg::in_item_t item,
	output bbg_pkg::state_t   nxt,
	output bbg_pkg::out_item_t res
);
	import bbg_pkg::*;

	logic pend;
	logic [31:0] elapsed;

	assign pend = (cur.start_pending | item.start_pulse) & ~item.cancel_pulse;
	assign elapsed = item.now_ms - cur.phase_stamp;

	always_comb begin
		nxt = cur;
		nxt.start_pending = pend;
		priority if (!item.beep_enable) begin
			nxt.pin_active = 1'b0;
		end else if (pend) begin
			nxt.pin_active = 1'b1;
			nxt.phase_stamp = item.now_ms;
			nxt.remaining = cfg.beeps_per_burst - 8'd1;
			nxt.start_pending = 1'b0;
		end else if (cur.pin_active) begin
			if (elapsed >= {16'd0, cfg.on_time_ms}) begin
				nxt.pin_active = 1'b0;
				nxt.phase_stamp = item.now_ms;
			end
		end else if (cur.remaining != 8'd0) begin
			if (elapsed >= {16'd0, cfg.gap_time_ms}) begin
				nxt.pin_active = 1'b1;
				nxt.phase_stamp = item.now_ms;
				nxt.remaining = cur.remaining - 8'd1;
			end
		end else if (cfg.repeat_wait_ms != 16'd0
				&& elapsed >= {16'd0, cfg.repeat_wait_ms}) begin
			nxt.start_pending = 1'b1;
		end
	end

	assign res.buzzer_on = nxt.pin_active;
	assign res.beeps_left = nxt.remaining;

endmodule

`default_nettype wire

// ===== src/beep_burst_generator_top.sv =====
// -----------------------------------------------------------------------------
// beep_burst_generator_top
// buzzer burst timer: beeps of set on time and gap, optional repeating burst
// -----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall / in_data) carries one time sample per
//   transfer: millisecond time, enable level, start and cancel pulses
//   output channel (out_valid / out_stall / out_data) returns one result per
//   input transfer: buzzer level and beeps left in the burst
//   cfg_we / cfg_index / cfg_data write the four config registers; the user
//   must do so only while no transfer is in flight; the block does not enforce it
// flow: an item waits in the input register until the output register is free,
//   and its result is then registered in the output register
// throughput: one item per cycle unless out_stall holds a result; the whole
//   step is one 32-bit subtract and three compares between the two registers
// stall: while the output register holds an untaken result the input register
//   keeps its item; in_stall rises only when both are full
// reset: burst state clears, registers return to their default timing,
//   both pipeline registers are empty
// -----------------------------------------------------------------------------
`default_nettype none
`include "beep_burst_generator_top_assert.svh"

module beep_burst_generator_top (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_stall,
	input  bbg_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  wire                           out_stall,
	output bbg_pkg::out_item_t            out_data,
	input  wire                           cfg_we,
	input  wire [bbg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [bbg_pkg::CFG_W-1:0]      cfg_data
);
	import bbg_pkg::*;

	cfg_t      cfg_q;
	state_t    st_q;
	state_t    st_nxt;
	in_item_t  data_s1;
	logic      valid_s1;
	out_item_t res;
	logic      adv;

	// the input register moves into the output register when that one is free
	assign adv = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !adv;

	bbg_step u_step (
		.cur  (st_q),
		.cfg  (cfg_q),
		.item (data_s1),
		.nxt  (st_nxt),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.beeps_per_burst <= RST_BEEPS_PER_BURST;
			cfg_q.on_time_ms <= RST_ON_TIME;
			cfg_q.gap_time_ms <= RST_GAP_TIME;
			cfg_q.repeat_wait_ms <= RST_REPEAT_WAIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BEEPS_PER_BURST: cfg_q.beeps_per_burst <= cfg_data[7:0];
				REG_ON_TIME: cfg_q.on_time_ms <= cfg_data;
				REG_GAP_TIME: cfg_q.gap_time_ms <= cfg_data;
				REG_REPEAT_WAIT: cfg_q.repeat_wait_ms <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (adv) begin
				st_q <= st_nxt;
			end
			if (adv) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data <= res;
		end
	end

	// input side only stalls with a held item
	`BBG_ASSERT(a_stall_needs_item, !in_stall || valid_s1)
	// a fresh result mirrors the burst state it was taken from
	`BBG_ASSERT_NEXT(a_result_matches_state, adv,
		out_data.buzzer_on == st_q.pin_active && out_data.beeps_left == st_q.remaining)
	// a disabled transfer always silences the buzzer
	`BBG_ASSERT_NEXT(a_disable_silences, adv && !data_s1.beep_enable, !st_q.pin_active)
	// burst state only moves with a transfer into the output register
	`BBG_ASSERT_NEXT(a_state_holds, !adv, $stable(st_q))

endmodule

`default_nettype wire
